@@ rtl/video_graphics_sequencer_macros.svh @@
// Assertion macros shared by the graphics sequencer RTL.
`ifndef VIDEO_GRAPHICS_SEQUENCER_MACROS_SVH
`define VIDEO_GRAPHICS_SEQUENCER_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off during reset
`define VGS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vgs assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define VGS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vgs assertion failed");
`else
`define VGS_ASSERT_IMP(lbl, ante, cons)
`define VGS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/vgs_pkg.sv @@
// Types and constants of the video graphics sequencer.
package vgs_pkg;

	// display mode codes {ECM, BMM, MCM}
	localparam logic [2:0] MODE_STD_TEXT = 3'b000;
	localparam logic [2:0] MODE_MC_TEXT  = 3'b001;
	localparam logic [2:0] MODE_STD_BMP  = 3'b010;
	localparam logic [2:0] MODE_MC_BMP   = 3'b011;
	localparam logic [2:0] MODE_ECM_TEXT = 3'b100;

	// multicolor pixel pair codes
	localparam logic [1:0] CB_BG0 = 2'b00;
	localparam logic [1:0] CB_C1  = 2'b01;
	localparam logic [1:0] CB_C2  = 2'b10;
	localparam logic [1:0] CB_C3  = 2'b11;

	localparam int unsigned NUM_BG   = 4;
	localparam int unsigned BG_IDX_W = 2;
	localparam int unsigned ADDR_W   = 4;

	typedef logic [3:0] color_t;
	typedef color_t bg_array_t [NUM_BG];

	// pixel attributes handed to the color select
	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] cbits;
		logic [7:0] lchar;
		color_t     lcolor;
		logic       mcd;
	} vgs_sel_t;

endpackage

@@ rtl/vgs_color_sel.sv @@
// Color and foreground selection for one pixel from mode and color bits.
module vgs_color_sel
	import vgs_pkg::*;
(
	input  vgs_sel_t  sel,
	input  bg_array_t bg,
	output color_t    color,
	output logic      fg
);

	logic b0;
	assign b0 = sel.cbits[0];

	// mode decode
	always_comb begin
		color = '0;
		unique case (sel.mode)
			MODE_STD_TEXT: begin
				color = b0 ? sel.lcolor : bg[0];
			end
			MODE_MC_TEXT: begin
				if (!sel.lcolor[3]) begin
					color = b0 ? sel.lcolor : bg[0];
				end else begin
					case (sel.cbits)
						CB_BG0:  color = bg[0];
						CB_C1:   color = bg[1];
						CB_C2:   color = bg[2];
						default: color = {1'b0, sel.lcolor[2:0]};
					endcase
				end
			end
			MODE_STD_BMP: begin
				color = b0 ? sel.lchar[7:4] : sel.lchar[3:0];
			end
			MODE_MC_BMP: begin
				case (sel.cbits)
					CB_BG0:  color = bg[0];
					CB_C1:   color = sel.lchar[7:4];
					CB_C2:   color = sel.lchar[3:0];
					default: color = sel.lcolor;
				endcase
			end
			MODE_ECM_TEXT: begin
				color = b0 ? sel.lcolor : bg[sel.lchar[7:6]];
			end
			// ECM combined with BMM or MCM shows black
			default: color = '0;
		endcase
	end

	// foreground: upper bit in multicolor, any set bit otherwise
	assign fg = sel.mcd ? sel.cbits[1] : (sel.cbits != CB_BG0);

endmodule

@@ rtl/video_graphics_sequencer.sv @@
// Top level of the video graphics sequencer: pixel stream in, colored pixel out.
// Output: the result of an accepted pixel word is held in the output register.
// Throughput: one pixel per cycle unless the output is full and m_tready is low;
//   the shift, toggle and color logic all settle within the cycle before the result register.
// Reset (arst_n low): shift register, latched bytes, toggle, color bits and
//   background colors clear to zero; the output register empties.
`include "video_graphics_sequencer_macros.svh"
module video_graphics_sequencer
	import vgs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// pixel input
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,  // graphics_byte[7:0], screen_code[15:8],
	                                    // color_nibble[19:16], display_mode[22:20],
	                                    // shift_multicolor[23], clear_mc_toggle[24]
	input  logic              s_tuser,  // load_graphics[0]
	// pixel output
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,  // pixel_color[3:0], is_foreground[4]
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// input field unpacking
	logic [7:0] graphics_byte;
	logic [7:0] screen_code;
	color_t     color_nibble;
	logic [2:0] display_mode;
	logic       shift_multicolor;
	logic       clear_mc_toggle;
	logic       load_graphics;

	assign graphics_byte    = s_tdata[7:0];
	assign screen_code      = s_tdata[15:8];
	assign color_nibble     = s_tdata[19:16];
	assign display_mode     = s_tdata[22:20];
	assign shift_multicolor = s_tdata[23];
	assign clear_mc_toggle  = s_tdata[24];
	assign load_graphics    = s_tuser;

	// sequencer state
	logic [7:0] shift_q;
	logic [7:0] char_q;
	color_t     lcolor_q;
	logic       toggle_q;
	logic [1:0] cbits_q;
	bg_array_t  bg_q;

	// output register
	logic       out_valid_q;
	color_t     out_color_q;
	logic       out_fg_q;

	logic in_acc;
	assign s_tready = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;

	// configuration port
	logic cfg_wr;
	logic addr_ok;
	assign pready  = 1'b1;
	assign addr_ok = (paddr[1:0] == 2'b00);
	assign cfg_wr  = psel && penable && pwrite && pready && addr_ok;
	assign prdata  = addr_ok ? {28'd0, bg_q[paddr[BG_IDX_W+1:2]]} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BG; i++) begin
				bg_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			bg_q[paddr[BG_IDX_W+1:2]] <= pwdata[3:0];
		end
	end

	// load and clear ahead of the pixel
	logic [7:0] sh_cur;
	logic [7:0] char_cur;
	color_t     lcolor_cur;
	logic       tog_cur;
	logic       mcd;
	logic       gen;
	logic [1:0] cbits_n;

	assign sh_cur     = load_graphics ? graphics_byte : shift_q;
	assign char_cur   = load_graphics ? screen_code : char_q;
	assign lcolor_cur = load_graphics ? color_nibble : lcolor_q;
	assign tog_cur    = load_graphics ? 1'b1 : (clear_mc_toggle ? 1'b0 : toggle_q);

	assign mcd = display_mode[0] && (display_mode[1] || lcolor_cur[3]);
	assign gen = shift_multicolor && (display_mode[1] || lcolor_cur[3]);

	// color bits: in multicolor shifting, taken (as pairs when mcd) only on toggle
	always_comb begin
		if (gen) begin
			if (tog_cur) begin
				cbits_n = mcd ? sh_cur[7:6] : {1'b0, sh_cur[7]};
			end else begin
				cbits_n = cbits_q;
			end
		end else begin
			cbits_n = mcd ? {sh_cur[7], 1'b0} : {1'b0, sh_cur[7]};
		end
	end

	vgs_sel_t sel;
	color_t   pix_color;
	logic     pix_fg;

	assign sel.mode   = display_mode;
	assign sel.cbits  = cbits_n;
	assign sel.lchar  = char_cur;
	assign sel.lcolor = lcolor_cur;
	assign sel.mcd    = mcd;

	vgs_color_sel u_color_sel (
		.sel   (sel),
		.bg    (bg_q),
		.color (pix_color),
		.fg    (pix_fg)
	);

	// state update per accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= '0;
			char_q   <= '0;
			lcolor_q <= '0;
			toggle_q <= 1'b0;
			cbits_q  <= '0;
		end else if (in_acc) begin
			shift_q  <= {sh_cur[6:0], 1'b0};
			char_q   <= char_cur;
			lcolor_q <= lcolor_cur;
			toggle_q <= !tog_cur;
			cbits_q  <= cbits_n;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_color_q <= pix_color;
			out_fg_q    <= pix_fg;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_fg_q, out_color_q};

	// checks
	`VGS_ASSERT_IMP(a_stall_only_when_full, !s_tready, out_valid_q)
	`VGS_ASSERT_NEXT(a_load_toggle, in_acc && load_graphics, !toggle_q)
	`VGS_ASSERT_NEXT(a_toggle_flips, in_acc && !load_graphics && !clear_mc_toggle, toggle_q != $past(toggle_q))
	`VGS_ASSERT_NEXT(a_shift_advance, in_acc && !load_graphics, shift_q == {$past(shift_q[6:0]), 1'b0})
	`VGS_ASSERT_NEXT(a_bad_mode_black, in_acc && display_mode[2] && (display_mode[1] || display_mode[0]), out_color_q == '0)

endmodule

@@ verif/tb_top.sv @@
// Testbench of the video graphics sequencer: directed and random pixel words checked by a predictor.
module tb_top;
	import vgs_pkg::*;

	localparam int unsigned RAND_PIXELS  = 850;
	localparam int unsigned NUM_PHASES   = 5;
	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned SETTLE_EDGES = 4;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DIR_ROWS     = 24;

	// register indexes
	localparam int unsigned REG_BG0 = 0;
	localparam int unsigned REG_BG1 = 1;
	localparam int unsigned REG_BG2 = 2;
	localparam int unsigned REG_BG3 = 3;

	// ECM together with BMM or MCM: no valid picture
	localparam logic [2:0] MODE_ECM_MC     = 3'b101;
	localparam logic [2:0] MODE_ECM_BMP    = 3'b110;
	localparam logic [2:0] MODE_ECM_MC_BMP = 3'b111;

	// background colors used by the directed part
	localparam color_t DIR_BG0 = 4'h6;
	localparam color_t DIR_BG1 = 4'hE;
	localparam color_t DIR_BG2 = 4'h3;
	localparam color_t DIR_BG3 = 4'hA;

	typedef struct packed {
		logic       load;
		logic [7:0] gbyte;
		logic [7:0] scode;
		logic [3:0] cnib;
		logic [2:0] mode;
		logic       smc;
		logic       clr;
	} pix_in_t;

	typedef struct packed {
		color_t color;
		logic   fg;
	} pix_out_t;

	typedef struct packed {
		pix_in_t  px;
		logic     typed;
		pix_out_t want;
	} dir_row_t;

	localparam pix_out_t NO_TYPED_OUT = '0;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [31:0]       s_tdata  = '0;
	logic              s_tuser  = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic [31:0]       prdata;
	logic              pready;

	// predictor state and its copy of the background registers
	color_t     bg_cfg [NUM_BG];
	logic [7:0] sh_reg;
	logic [7:0] lat_char;
	logic [3:0] lat_color;
	logic       mc_tog;
	logic [1:0] cbits;

	pix_out_t pending_pixels [$];
	dir_row_t dir_tab [DIR_ROWS];
	int       errors = 0;
	int       cycles = 0;
	bit       hold_req = 1'b0;

	video_graphics_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// one pixel tick: load, shift, toggle, then color select
	function automatic pix_out_t sequence_pixel(input pix_in_t p);
		pix_out_t r;
		logic     ecm, bmm, mcm, mcchar, mcd, gen;
		ecm = p.mode[2];
		bmm = p.mode[1];
		mcm = p.mode[0];
		// clear first so that a load in the same pixel still sets the toggle
		if (p.clr)
			mc_tog = 1'b0;
		if (p.load) begin
			sh_reg    = p.gbyte;
			lat_char  = p.scode;
			lat_color = p.cnib;
			mc_tog    = 1'b1;
		end
		mcchar = lat_color[3];
		mcd    = mcm & (bmm | mcchar);
		gen    = p.smc & (bmm | mcchar);
		// two-bit pairs are only taken on toggle pixels
		if (gen) begin
			if (mc_tog)
				cbits = mcd ? sh_reg[7:6] : {1'b0, sh_reg[7]};
		end else begin
			cbits = mcd ? {sh_reg[7], 1'b0} : {1'b0, sh_reg[7]};
		end
		sh_reg = sh_reg << 1;
		mc_tog = ~mc_tog;

		r.color = 4'h0;
		case (p.mode)
			MODE_STD_TEXT: r.color = cbits[0] ? lat_color : bg_cfg[REG_BG0];
			MODE_MC_TEXT: begin
				if (!mcchar)
					r.color = cbits[0] ? lat_color : bg_cfg[REG_BG0];
				else
					case (cbits)
						CB_BG0:  r.color = bg_cfg[REG_BG0];
						CB_C1:   r.color = bg_cfg[REG_BG1];
						CB_C2:   r.color = bg_cfg[REG_BG2];
						default: r.color = {1'b0, lat_color[2:0]};
					endcase
			end
			MODE_STD_BMP: r.color = cbits[0] ? lat_char[7:4] : lat_char[3:0];
			MODE_MC_BMP:
				case (cbits)
					CB_BG0:  r.color = bg_cfg[REG_BG0];
					CB_C1:   r.color = lat_char[7:4];
					CB_C2:   r.color = lat_char[3:0];
					default: r.color = lat_color;
				endcase
			MODE_ECM_TEXT: r.color = cbits[0] ? lat_color : bg_cfg[lat_char[7:6]];
			default: r.color = 4'h0;
		endcase
		// foreground flag is kept even in invalid modes
		r.fg = mcd ? cbits[1] : (cbits != CB_BG0);
		return r;
	endfunction

	// compare one output word with the oldest expectation
	function automatic void check_pixel(input logic [7:0] d);
		pix_out_t want;
		if (pending_pixels.size() == 0) begin
			$display("%0t: unexpected pixel word, expected none, actual %h", $time, d);
			errors++;
			return;
		end
		want = pending_pixels.pop_front();
		if (d[3:0] !== want.color) begin
			$display("%0t: pixel_color expected %h actual %h", $time, want.color, d[3:0]);
			errors++;
		end
		if (d[4] !== want.fg) begin
			$display("%0t: is_foreground expected %b actual %b", $time, want.fg, d[4]);
			errors++;
		end
	endfunction

	// register write plus read-back
	task automatic write_bg(input int unsigned idx, input color_t val);
		logic [31:0] rd;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 4);
		pwdata  <= {28'b0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		bg_cfg[idx] = val;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== {28'b0, val}) begin
			$display("%0t: read of register %0d expected %h actual %h", $time, idx,
				{28'b0, val}, rd);
			errors++;
		end
	endtask

	task automatic set_backgrounds(input color_t c0, input color_t c1, input color_t c2,
			input color_t c3);
		write_bg(REG_BG0, c0);
		write_bg(REG_BG1, c1);
		write_bg(REG_BG2, c2);
		write_bg(REG_BG3, c3);
	endtask

	// offer one pixel word, predict it once accepted
	task automatic send_pixel(input pix_in_t p, input logic typed, input pix_out_t want,
			input logic quiet);
		int unsigned gap;
		pix_out_t    calc;
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, p.clr, p.smc, p.mode, p.cnib, p.scode, p.gbyte};
		s_tuser  <= p.load;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		calc = sequence_pixel(p);
		pending_pixels.push_back(typed ? want : calc);
	endtask

	// stop offering and wait for every expected pixel
	task automatic settle_pixels();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_EDGES) @(posedge clk);
	endtask

	// one character cell: load on the first pixel, then shift, mostly in the same mode
	task automatic send_char(inout int unsigned sent);
		pix_in_t     p;
		int unsigned len;
		logic        quiet;
		logic [2:0]  mode;
		logic        smc;
		case ($urandom_range(0, 9))
			0, 1:    mode = MODE_STD_TEXT;
			2, 3:    mode = MODE_MC_TEXT;
			4:       mode = MODE_STD_BMP;
			5, 6:    mode = MODE_MC_BMP;
			7:       mode = MODE_ECM_TEXT;
			default: mode = 3'($urandom_range(0, 7));
		endcase
		smc   = ($urandom_range(0, 7) == 0) ? ~mode[0] : mode[0];
		len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 8;
		quiet = ($urandom_range(0, 4) == 0);
		for (int unsigned k = 0; k < len; k++) begin
			p.load  = (k == 0);
			p.gbyte = 8'($urandom);
			p.scode = 8'($urandom);
			p.cnib  = 4'($urandom);
			p.mode  = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(0, 7)) : mode;
			p.smc   = smc;
			p.clr   = (k == 0 && $urandom_range(0, 3) == 0) || ($urandom_range(0, 31) == 0);
			send_pixel(p, 1'b0, NO_TYPED_OUT, quiet);
			sent++;
		end
	endtask

	// output side: random stalls, quiet stretches, and one long hold-off
	initial begin
		int unsigned gap;
		logic        quiet;
		quiet = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if ($urandom_range(0, 29) == 0)
					quiet = ~quiet;
				gap = quiet ? 0 : $urandom_range(0, 11);
				if (gap != 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			check_pixel(m_tdata);
		end
	end

	// stimulus
	initial begin
		pix_in_t     p;
		int unsigned sent;
		bit          paused;
		for (int i = 0; i < NUM_BG; i++)
			bg_cfg[i] = '0;
		sh_reg    = '0;
		lat_char  = '0;
		lat_color = '0;
		mc_tog    = 1'b0;
		cbits     = '0;
		paused    = 1'b0;
		// directed rows: {load, graphics, screen, color, mode, smc, clear}, typed, expected
		dir_tab = '{
			// nothing loaded yet: zero pixel on background zero
			'{'{1'b0, 8'h00, 8'h00, 4'h0, MODE_STD_TEXT, 1'b0, 1'b0}, 1'b1, '{DIR_BG0, 1'b0}},
			'{'{1'b1, 8'hFF, 8'h00, 4'hF, MODE_STD_TEXT, 1'b0, 1'b0}, 1'b1, '{4'hF, 1'b1}},
			'{'{1'b0, 8'h00, 8'h00, 4'h0, MODE_STD_TEXT, 1'b0, 1'b0}, 1'b0, NO_TYPED_OUT},
			'{'{1'b1, 8'h00, 8'h00, 4'h0, MODE_STD_TEXT, 1'b0, 1'b0}, 1'b1, '{DIR_BG0, 1'b0}},
			// multicolor character: pairs on toggle pixels, toggle cleared mid-run
			'{'{1'b1, 8'hA5, 8'h3C, 4'h9, MODE_MC_TEXT, 1'b1, 1'b0}, 1'b0, NO_TYPED_OUT},
			'{'{1'b0, 8'h00, 8'h00, 4'h0, MODE_MC_TEXT, 1'b1, 1'b0}, 1'b0, NO_TYPED_OUT},
			'{'{1'b0, 8'h00, 8'h00, 4'h0, MODE_MC_TEXT, 1'b1, 1'b0}, 1'b0, NO_TYPED_OUT},
			'{'{1'b0, 8'h00, 8'h00, 4'h0, MODE_MC_TEXT, 1'b1, 1'b1}, 1'b0, NO_TYPED_OUT},
			'{'{1'b1, 8'hC6, 8'h00, 4'h7, MODE_MC_TEXT, 1'b1, 1'b0}, 1'b0, NO_TYPED_OUT},
			'{'{1'b1, 8'h5A, 8'hE1, 4'h3, MODE_STD_BMP, 1'b0, 1'b0}, 1'b0, NO_TYPED_OUT},
			'{'{1'b0, 8'h00, 8'h00, 4'h0, MODE_STD_BMP, 1'b0, 1'b0}, 1'b0, NO_TYPED_OUT},
			'{'{1'b1, 8'h1B, 8'hF0, 4'hC, MODE_MC_BMP, 1'b1, 1'b0}, 1'b0, NO_TYPED_OUT},
			'{'{1'b0, 8'h00, 8'h00, 4'h0, MODE_MC_BMP, 1'b1, 1'b0}, 1'b0, NO_TYPED_OUT},
			'{'{1'b0, 8'h00, 8'h00, 4'h0, MODE_MC_BMP, 1'b1, 1'b0}, 1'b0, NO_TYPED_OUT},
			// clear and load on the same pixel
			'{'{1'b1, 8'hE4, 8'hFF, 4'hF, MODE_MC_BMP, 1'b1, 1'b1}, 1'b0, NO_TYPED_OUT},
			// extended background: screen code bits 7:6 pick the background
			'{'{1'b1, 8'h55, 8'hC0, 4'h6, MODE_ECM_TEXT, 1'b0, 1'b0}, 1'b0, NO_TYPED_OUT},
			'{'{1'b1, 8'h00, 8'h40, 4'h6, MODE_ECM_TEXT, 1'b0, 1'b0}, 1'b0, NO_TYPED_OUT},
			'{'{1'b1, 8'h00, 8'h80, 4'h2, MODE_ECM_TEXT, 1'b0, 1'b0}, 1'b0, NO_TYPED_OUT},
			// invalid modes give color zero
			'{'{1'b1, 8'h00, 8'h00, 4'h0, MODE_ECM_MC, 1'b0, 1'b0}, 1'b1, '{4'h0, 1'b0}},
			'{'{1'b1, 8'h00, 8'h00, 4'h0, MODE_ECM_BMP, 1'b0, 1'b0}, 1'b1, '{4'h0, 1'b0}},
			'{'{1'b1, 8'h00, 8'h00, 4'h0, MODE_ECM_MC_BMP, 1'b0, 1'b0}, 1'b1, '{4'h0, 1'b0}},
			'{'{1'b1, 8'hFF, 8'hFF, 4'hF, MODE_ECM_MC_BMP, 1'b1, 1'b1}, 1'b0, NO_TYPED_OUT},
			'{'{1'b0, 8'hFF, 8'hFF, 4'hF, MODE_MC_TEXT, 1'b1, 1'b0}, 1'b0, NO_TYPED_OUT},
			// multicolor shift outside multicolor mode
			'{'{1'b1, 8'h81, 8'h00, 4'h8, MODE_STD_TEXT, 1'b1, 1'b0}, 1'b0, NO_TYPED_OUT}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		set_backgrounds(DIR_BG0, DIR_BG1, DIR_BG2, DIR_BG3);

		for (int i = 0; i < DIR_ROWS; i++)
			send_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].want, 1'b0);
		settle_pixels();

		// random phases, each with its own background setting
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0:       set_backgrounds(4'h0, 4'h0, 4'h0, 4'h0);
				1:       set_backgrounds(4'hF, 4'hF, 4'hF, 4'hF);
				default: set_backgrounds(4'($urandom), 4'($urandom), 4'($urandom),
						4'($urandom));
			endcase
			// output side stalls long while words keep coming
			if (ph == 2)
				hold_req = 1'b1;
			sent = 0;
			while (sent < RAND_PIXELS / NUM_PHASES) begin
				if (ph == 3 && !paused && sent >= 80) begin
					settle_pixels();
					paused = 1'b1;
				end
				if ($urandom_range(0, 9) < 8) begin
					send_char(sent);
				end else begin
					p.load  = ($urandom_range(0, 3) == 0);
					p.gbyte = 8'($urandom);
					p.scode = 8'($urandom);
					p.cnib  = 4'($urandom);
					p.mode  = 3'($urandom_range(0, 7));
					p.smc   = 1'($urandom);
					p.clr   = 1'($urandom);
					send_pixel(p, 1'b0, NO_TYPED_OUT, 1'b0);
					sent++;
				end
			end
			settle_pixels();
		end

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/vgs_pkg.sv
rtl/vgs_color_sel.sv
rtl/video_graphics_sequencer.sv
verif/tb_top.sv
